// ----- hdl/bfia_pkg.sv -----
// Shared types and constants for the blob follow / IR avoid steering block.
`timescale 1ns / 1ps
`default_nettype none

package bfia_pkg;

    // Request kinds on the input channel
    localparam logic REQ_BLOB  = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLLOW_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BLOB_ROW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BLOB_AREA = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_AREA   = 3'd4;

    // Result field widths
    localparam int unsigned SPEED_W = 12;
    localparam int unsigned TURN_W  = 13;

    // Speed and turn limits (1/65536 m/s, 1/4096 rad/s)
    localparam logic [SPEED_W-1:0]       SPEED_MAX = 12'd3277;
    localparam logic signed [TURN_W-1:0] TURN_MAX  = 13'sd3217;
    localparam logic signed [TURN_W-1:0] TURN_IDLE = 13'sd1229;

    // Avoid mode: speed = 48*m - 23593, idle turn below 0.01 m/s and 0.1 rad
    localparam int unsigned AVOID_SPEED_GAIN = 48;
    localparam int unsigned AVOID_SPEED_OFS  = 23593;
    localparam int unsigned AVOID_SLOW       = 656;
    localparam int unsigned AVOID_STRAIGHT   = 410;

    // Follow mode IR safety gate (0.1 m outer, 0.08 m inner)
    localparam int unsigned GATE_OUTER = 409;
    localparam int unsigned GATE_INNER = 327;

    // Turn = round(x*4096/125); offsets of 99 px and more saturate
    localparam int unsigned TURN_MAG_SAT = 99;
    localparam int unsigned TURN_RND     = 62;
    localparam logic [19:0] TURN_RECIP   = 20'd536871;  // ceil(2^26/125)
    localparam int unsigned TURN_SHIFT   = 26;

    // Speed = round(d*65536/22500); differences above 1125 saturate
    localparam int unsigned SPEED_DIFF_SAT = 1125;
    localparam int unsigned SPEED_RND      = 11250;
    localparam logic [22:0] SPEED_RECIP    = 23'd6108398;  // ceil(2^37/22500)
    localparam int unsigned SPEED_SHIFT    = 37;

    // Reset values of the held state
    localparam int unsigned SMOOTH_RESET = 13000;

    // Per-request update strobes from the input stage
    typedef struct packed {
        logic blob_en;
        logic frame_en;
    } step_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/bfia_blob_select.sv -----
// Per-frame blob choice: keeps the chosen blob of the current frame.
`timescale 1ns / 1ps
`default_nettype none

module bfia_blob_select #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned AREA_BITS  = 24
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  bfia_pkg::step_ctrl_t    ctrl,
    input  wire  [COORD_BITS-1:0]   blob_x,
    input  wire  [COORD_BITS-1:0]   blob_y,
    input  wire  [AREA_BITS-1:0]    blob_area,
    input  wire  [COORD_BITS-1:0]   min_blob_row,
    output logic [COORD_BITS-1:0]   best_col,
    output logic [COORD_BITS-1:0]   best_row,
    output logic [AREA_BITS-1:0]    best_size,
    output logic                    has_blob
);

    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic [AREA_BITS-1:0]  size_reg;
    logic                  has_reg;
    logic                  take;

    // First blob of a frame always wins; later ones need row and larger area
    assign take = ctrl.blob_en &&
                  (!has_reg || (blob_y > min_blob_row && blob_area > size_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            size_reg <= '0;
            has_reg  <= 1'b0;
        end else if (take) begin
            col_reg  <= blob_x;
            row_reg  <= blob_y;
            size_reg <= blob_area;
            has_reg  <= 1'b1;
        end else if (ctrl.frame_en) begin
            has_reg  <= 1'b0;
        end
    end

    assign best_col  = col_reg;
    assign best_row  = row_reg;
    assign best_size = size_reg;
    assign has_blob  = has_reg;

endmodule

`default_nettype wire

// ----- hdl/bfia_steer.sv -----
// Frame-end steering math: avoid and follow laws, area smoothing, held turn.
`timescale 1ns / 1ps
`default_nettype none

module bfia_steer #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned AREA_BITS  = 24,
    parameter int unsigned RANGE_BITS = 13
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  frame_en,
    input  wire                                  follow_mode,
    input  wire  [COORD_BITS-1:0]                image_width,
    input  wire  [COORD_BITS-1:0]                min_blob_row,
    input  wire  [AREA_BITS-1:0]                 min_blob_area,
    input  wire  [AREA_BITS-1:0]                 target_area,
    input  wire  [COORD_BITS-1:0]                best_col,
    input  wire  [COORD_BITS-1:0]                best_row,
    input  wire  [AREA_BITS-1:0]                 best_size,
    input  wire                                  has_blob,
    input  wire  [RANGE_BITS-1:0]                range_lo,
    input  wire  [RANGE_BITS-1:0]                range_li,
    input  wire  [RANGE_BITS-1:0]                range_ls,
    input  wire  [RANGE_BITS-1:0]                range_rs,
    input  wire  [RANGE_BITS-1:0]                range_ri,
    input  wire  [RANGE_BITS-1:0]                range_ro,
    output logic [bfia_pkg::SPEED_W-1:0]         speed,
    output logic signed [bfia_pkg::TURN_W-1:0]   turn,
    output logic                                 seen
);

    localparam int unsigned RW = RANGE_BITS + 8;   // avoid-mode signed width
    localparam int unsigned XW = COORD_BITS + 1;   // signed column offset
    localparam int unsigned SW = AREA_BITS + 2;    // smoothing sum
    localparam int unsigned SPW = bfia_pkg::SPEED_W;
    localparam int unsigned TW  = bfia_pkg::TURN_W;

    localparam logic signed [RW-1:0] K20    = RW'(20);
    localparam logic signed [RW-1:0] K10    = RW'(10);
    localparam logic signed [RW-1:0] K5     = RW'(5);
    localparam logic signed [RW-1:0] KGAIN  = RW'(bfia_pkg::AVOID_SPEED_GAIN);
    localparam logic signed [RW-1:0] KOFS   = RW'(bfia_pkg::AVOID_SPEED_OFS);
    localparam logic signed [RW-1:0] KSLOW  = RW'(bfia_pkg::AVOID_SLOW);
    localparam logic signed [RW-1:0] KSTR   = RW'(bfia_pkg::AVOID_STRAIGHT);
    localparam logic signed [RW-1:0] KSMAX  = RW'(bfia_pkg::SPEED_MAX);
    localparam logic signed [RW-1:0] KTMAX  = RW'(bfia_pkg::TURN_MAX);
    localparam logic signed [RW-1:0] KTIDLE = RW'(bfia_pkg::TURN_IDLE);

    logic [AREA_BITS-1:0]      smooth_reg, smooth_next;
    logic signed [TW-1:0]      turn_rate_reg, turn_rate_next;

    // ---- avoid mode ----
    logic [RANGE_BITS-1:0]     min_a, min_b, min_all;
    logic signed [RW-1:0]      raw_speed, t_raw, t_abs, t_adj;
    logic [SPW-1:0]            avoid_speed;
    logic signed [TW-1:0]      avoid_turn;

    assign min_a   = (range_li < range_lo) ? range_li : range_lo;
    assign min_b   = (range_ro < range_ri) ? range_ro : range_ri;
    assign min_all = (min_b < min_a) ? min_b : min_a;

    assign raw_speed = KGAIN * RW'(min_all) - KOFS;
    assign t_raw = K20 * (RW'(range_lo) - RW'(range_ro))
                 + K10 * (RW'(range_li) - RW'(range_ri))
                 + K5  * (RW'(range_ls) - RW'(range_rs));
    assign t_abs = t_raw[RW-1] ? -t_raw : t_raw;
    // Nearly stopped and pointing straight: spin in place
    assign t_adj = (raw_speed < KSLOW && t_abs < KSTR) ? KTIDLE : t_raw;

    always_comb begin
        if (raw_speed[RW-1]) begin
            avoid_speed = '0;
        end else if (raw_speed > KSMAX) begin
            avoid_speed = bfia_pkg::SPEED_MAX;
        end else begin
            avoid_speed = raw_speed[SPW-1:0];
        end
        if (t_adj > KTMAX) begin
            avoid_turn = bfia_pkg::TURN_MAX;
        end else if (t_adj < -KTMAX) begin
            avoid_turn = -bfia_pkg::TURN_MAX;
        end else begin
            avoid_turn = t_adj[TW-1:0];
        end
    end

    // ---- follow mode: turn from column offset ----
    logic                      qualify, gate;
    logic signed [XW-1:0]      x_off;
    logic [COORD_BITS-1:0]     x_mag;
    logic [18:0]               turn_num;
    logic [38:0]               turn_prod;
    logic [SPW-1:0]            turn_mag;
    logic signed [TW-1:0]      follow_turn;

    assign qualify = has_blob && (best_row > min_blob_row) && (best_size > min_blob_area);
    assign gate = (range_lo > RANGE_BITS'(bfia_pkg::GATE_OUTER)) &&
                  (range_li > RANGE_BITS'(bfia_pkg::GATE_INNER)) &&
                  (range_ri > RANGE_BITS'(bfia_pkg::GATE_INNER)) &&
                  (range_ro > RANGE_BITS'(bfia_pkg::GATE_OUTER));

    assign x_off = XW'(image_width >> 1) - XW'(best_col);
    assign x_mag = x_off[XW-1] ? COORD_BITS'(-x_off) : x_off[COORD_BITS-1:0];

    // Divide by 125 through a reciprocal; only offsets below saturation matter
    assign turn_num  = {x_mag[6:0], 12'd0} + 19'(bfia_pkg::TURN_RND);
    assign turn_prod = 39'(turn_num) * 39'(bfia_pkg::TURN_RECIP);

    always_comb begin
        if (x_mag >= COORD_BITS'(bfia_pkg::TURN_MAG_SAT)) begin
            turn_mag = SPW'(bfia_pkg::TURN_MAX);
        end else begin
            turn_mag = turn_prod[bfia_pkg::TURN_SHIFT +: SPW];
        end
        follow_turn = x_off[XW-1] ? -$signed({1'b0, turn_mag}) : $signed({1'b0, turn_mag});
    end

    // ---- follow mode: quarter-weight area average and speed ----
    logic [SW-1:0]             smooth_sum;
    logic [AREA_BITS-1:0]      smooth_new, area_diff;
    logic [26:0]               spd_num;
    logic [49:0]               spd_prod;
    logic [SPW-1:0]            follow_speed;

    assign smooth_sum = SW'(3) * SW'(smooth_reg) + SW'(best_size);
    assign smooth_new = smooth_sum[SW-1:2];
    assign area_diff  = target_area - smooth_new;

    // Divide by 22500 through a reciprocal
    assign spd_num  = {area_diff[10:0], 16'd0} + 27'(bfia_pkg::SPEED_RND);
    assign spd_prod = 50'(spd_num) * 50'(bfia_pkg::SPEED_RECIP);

    always_comb begin
        if (target_area <= smooth_new) begin
            follow_speed = '0;
        end else if (area_diff > AREA_BITS'(bfia_pkg::SPEED_DIFF_SAT)) begin
            follow_speed = bfia_pkg::SPEED_MAX;
        end else begin
            follow_speed = spd_prod[bfia_pkg::SPEED_SHIFT +: SPW];
        end
    end

    // ---- result selection and state update ----
    always_comb begin
        speed          = '0;
        turn           = turn_rate_reg;
        seen           = 1'b0;
        turn_rate_next = turn_rate_reg;
        smooth_next    = smooth_reg;
        if (!follow_mode) begin
            speed          = avoid_speed;
            turn           = avoid_turn;
            turn_rate_next = avoid_turn;
        end else if (qualify) begin
            turn           = follow_turn;
            turn_rate_next = follow_turn;
            seen           = 1'b1;
            if (gate) begin
                speed       = follow_speed;
                smooth_next = smooth_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg    <= AREA_BITS'(bfia_pkg::SMOOTH_RESET);
            turn_rate_reg <= bfia_pkg::TURN_IDLE;
        end else if (frame_en) begin
            smooth_reg    <= smooth_next;
            turn_rate_reg <= turn_rate_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/blob_follow_ir_avoid_steering.sv -----
// Top level of the blob follow / IR avoid steering controller.
`timescale 1ns / 1ps
`default_nettype none

// Steering controller: blob requests (s_req_type 0) pick the frame's target blob
// and give no result; a frame-end request (s_req_type 1) carries six IR ranges
// and gives one speed/turn command on the m_ channel. One request is taken per
// clock unless a frame-end request is stalled while m_valid waits for m_ready; a
// frame-end result passes through the input and then the output register before
// it shows on m_valid. The input register feeds a single pass of logic whose
// longest path is the area average, a subtract and one constant-reciprocal
// multiply, and the output register lets the next request enter while a result
// waits. Configuration (cfg_index, cfg_data) is always ready and should only be
// written while the block is idle. Unknown register indexes are ignored.
module blob_follow_ir_avoid_steering #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned AREA_BITS  = 24,
    parameter int unsigned RANGE_BITS = 13
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // configuration writes
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [bfia_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [AREA_BITS-1:0]                  cfg_data,
    // requests
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire                                   s_req_type,
    input  wire  [COORD_BITS-1:0]                 s_blob_x,
    input  wire  [COORD_BITS-1:0]                 s_blob_y,
    input  wire  [AREA_BITS-1:0]                  s_blob_area,
    input  wire  [RANGE_BITS-1:0]                 s_range_left_outer,
    input  wire  [RANGE_BITS-1:0]                 s_range_left_inner,
    input  wire  [RANGE_BITS-1:0]                 s_range_left_side,
    input  wire  [RANGE_BITS-1:0]                 s_range_right_side,
    input  wire  [RANGE_BITS-1:0]                 s_range_right_inner,
    input  wire  [RANGE_BITS-1:0]                 s_range_right_outer,
    // results
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [bfia_pkg::SPEED_W-1:0]          m_speed_out,
    output logic signed [bfia_pkg::TURN_W-1:0]    m_turn_out,
    output logic                                  m_target_seen
);

    // Configuration registers
    logic                  follow_mode_reg;
    logic [COORD_BITS-1:0] image_width_reg, min_blob_row_reg;
    logic [AREA_BITS-1:0]  min_blob_area_reg, target_area_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            follow_mode_reg   <= 1'b1;
            image_width_reg   <= COORD_BITS'(320);
            min_blob_row_reg  <= COORD_BITS'(120);
            min_blob_area_reg <= AREA_BITS'(400);
            target_area_reg   <= AREA_BITS'(13000);
        end else if (cfg_valid) begin
            case (cfg_index)
                bfia_pkg::CFG_FOLLOW_MODE:   follow_mode_reg   <= cfg_data[0];
                bfia_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[COORD_BITS-1:0];
                bfia_pkg::CFG_MIN_BLOB_ROW:  min_blob_row_reg  <= cfg_data[COORD_BITS-1:0];
                bfia_pkg::CFG_MIN_BLOB_AREA: min_blob_area_reg <= cfg_data;
                bfia_pkg::CFG_TARGET_AREA:   target_area_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    logic                  in_valid_reg, in_type_reg;
    logic [COORD_BITS-1:0] in_x_reg, in_y_reg;
    logic [AREA_BITS-1:0]  in_area_reg;
    logic [RANGE_BITS-1:0] in_lo_reg, in_li_reg, in_ls_reg, in_rs_reg, in_ri_reg, in_ro_reg;
    logic                  is_frame, advance;
    bfia_pkg::step_ctrl_t  ctrl;

    assign is_frame = (in_type_reg == bfia_pkg::REQ_FRAME);
    // Blob requests never need the output slot
    assign advance  = in_valid_reg && (!is_frame || !m_valid || m_ready);
    assign s_ready  = !in_valid_reg || advance;

    assign ctrl.blob_en  = advance && !is_frame;
    assign ctrl.frame_en = advance && is_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_type_reg <= s_req_type;
            in_x_reg    <= s_blob_x;
            in_y_reg    <= s_blob_y;
            in_area_reg <= s_blob_area;
            in_lo_reg   <= s_range_left_outer;
            in_li_reg   <= s_range_left_inner;
            in_ls_reg   <= s_range_left_side;
            in_rs_reg   <= s_range_right_side;
            in_ri_reg   <= s_range_right_inner;
            in_ro_reg   <= s_range_right_outer;
        end
    end

    // Chosen blob of the frame
    logic [COORD_BITS-1:0] best_col, best_row;
    logic [AREA_BITS-1:0]  best_size;
    logic                  has_blob;

    bfia_blob_select #(
        .COORD_BITS (COORD_BITS),
        .AREA_BITS  (AREA_BITS)
    ) u_blob_select (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .blob_x       (in_x_reg),
        .blob_y       (in_y_reg),
        .blob_area    (in_area_reg),
        .min_blob_row (min_blob_row_reg),
        .best_col     (best_col),
        .best_row     (best_row),
        .best_size    (best_size),
        .has_blob     (has_blob)
    );

    // Steering command
    logic [bfia_pkg::SPEED_W-1:0]       speed;
    logic signed [bfia_pkg::TURN_W-1:0] turn;
    logic                               seen;

    bfia_steer #(
        .COORD_BITS (COORD_BITS),
        .AREA_BITS  (AREA_BITS),
        .RANGE_BITS (RANGE_BITS)
    ) u_steer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .frame_en      (ctrl.frame_en),
        .follow_mode   (follow_mode_reg),
        .image_width   (image_width_reg),
        .min_blob_row  (min_blob_row_reg),
        .min_blob_area (min_blob_area_reg),
        .target_area   (target_area_reg),
        .best_col      (best_col),
        .best_row      (best_row),
        .best_size     (best_size),
        .has_blob      (has_blob),
        .range_lo      (in_lo_reg),
        .range_li      (in_li_reg),
        .range_ls      (in_ls_reg),
        .range_rs      (in_rs_reg),
        .range_ri      (in_ri_reg),
        .range_ro      (in_ro_reg),
        .speed         (speed),
        .turn          (turn),
        .seen          (seen)
    );

    // Output register
    logic                               out_valid_reg;
    logic [bfia_pkg::SPEED_W-1:0]       out_speed_reg;
    logic signed [bfia_pkg::TURN_W-1:0] out_turn_reg;
    logic                               out_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.frame_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.frame_en) begin
            out_speed_reg <= speed;
            out_turn_reg  <= turn;
            out_seen_reg  <= seen;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_speed_out   = out_speed_reg;
    assign m_turn_out    = out_turn_reg;
    assign m_target_seen = out_seen_reg;

endmodule

`default_nettype wire
